// ----- sv/clns_pkg.sv -----
// ============================================================================
// clns_pkg
// Shared types, constants and phase helpers for the character LCD nibble
// sequencer (4-bit bus).
// ============================================================================
package clns_pkg;

    // Request opcodes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_GOTO   = 3'd3;
    localparam logic [2:0] OP_NUMBER = 3'd4;

    // Job kinds carried from front to back
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_NUMBER = 2'd2;

    // Sizing
    localparam int NUMBER_DIGITS_DEFAULT = 5;
    localparam int MAX_DIGITS            = 5;       // digits of a 16-bit value
    localparam int MAX_POS               = 25 / 4;  // position cap of a number run
    localparam int QUEUE_DEPTH           = 2;
    localparam logic [4:0] INIT_LAST_IDX = 5'd24;

    // LCD command bytes and characters
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [6:0] ROW1_BASE     = 7'h40;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    // Hold times in microseconds
    localparam logic [15:0] EN_HIGH_US    = 16'd1;
    localparam logic [15:0] EN_LOW_US     = 16'd100;
    localparam logic [15:0] BYTE_TAIL_US  = 16'd50;
    localparam logic [15:0] CLEAR_TAIL_US = 16'd2000;
    localparam logic [15:0] POWER_UP_US   = 16'd40000;
    localparam logic [15:0] WAKE0_US      = 16'd5000;
    localparam logic [15:0] WAKE1_US      = 16'd150;

    // Reciprocal of ten for 16-bit values: q = (v * 0xCCCD) >> 19
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [1:0]                   kind;
        logic                         rs;
        logic [7:0]                   byte_val;
        digit_t [MAX_DIGITS-1:0]      digits;   // least significant first
        logic [2:0]                   nd;       // digit count
        logic [2:0]                   npos;     // positions printed
    } job_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] wait_us;
    } phase_t;

    // One of the four phases of a byte: high nibble first, EN high then low
    function automatic phase_t byte_phase(input logic rs, input logic [7:0] b,
                                          input logic [1:0] ph);
        phase_t      p;
        logic [15:0] extra;
        extra = BYTE_TAIL_US;
        if (!rs && (b == CMD_CLEAR || b == CMD_HOME))
        begin
            extra = BYTE_TAIL_US + CLEAR_TAIL_US;
        end
        p.rs  = rs;
        p.nib = ph[1] ? b[3:0] : b[7:4];
        p.en  = ~ph[0];
        if (!ph[0])
        begin
            p.wait_us = EN_HIGH_US;
        end
        else if (ph[1])
        begin
            p.wait_us = EN_LOW_US + extra;
        end
        else
        begin
            p.wait_us = EN_LOW_US;
        end
        return p;
    endfunction

    // Power-up sequence, 25 phases
    function automatic phase_t init_phase(input logic [4:0] idx);
        phase_t      p;
        logic [4:0]  j;
        logic [7:0]  b;
        logic [15:0] extra;
        p = '0;
        j = 5'd0;
        b = 8'h00;
        extra = 16'd0;
        if (idx == 5'd0)
        begin
            p.rs      = 1'b0;
            p.nib     = 4'h0;
            p.en      = 1'b0;
            p.wait_us = POWER_UP_US;
        end
        else if (idx < 5'd9)
        begin
            // wake-up nibbles 3, 3, 3, then 2
            j = idx - 5'd1;
            case (j[2:1])
                2'd0:    extra = WAKE0_US;
                2'd1:    extra = WAKE1_US;
                default: extra = 16'd0;
            endcase
            p.rs      = 1'b0;
            p.nib     = (j[2:1] == 2'd3) ? NIB_4BIT : NIB_WAKE;
            p.en      = ~j[0];
            p.wait_us = j[0] ? (EN_LOW_US + extra) : EN_HIGH_US;
        end
        else
        begin
            j = idx - 5'd9;
            case (j[3:2])
                2'd0:    b = CMD_FUNC_4BIT;
                2'd1:    b = CMD_DISP_ON;
                2'd2:    b = CMD_ENTRY;
                default: b = CMD_CLEAR;
            endcase
            p = byte_phase(1'b0, b, j[1:0]);
        end
        return p;
    endfunction

endpackage

// ----- sv/clns_req_if.sv -----
// ============================================================================
// clns_req_if
// Request channel: one beat is one LCD request.
// ============================================================================
interface clns_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  byte_value;
    logic        row;
    logic [5:0]  column;
    logic [15:0] number;

    modport source (output valid, output opcode, output byte_value, output row,
                    output column, output number, input ready);
    modport sink   (input valid, input opcode, input byte_value, input row,
                    input column, input number, output ready);
endinterface

// ----- sv/clns_phase_if.sv -----
// ============================================================================
// clns_phase_if
// Pin phase channel: one beat is one phase of RS, D4..D7 and EN levels.
// ============================================================================
interface clns_phase_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  data_nibble;
    logic        enable;
    logic [15:0] wait_us;
    logic        last;

    modport source (output valid, output reg_select, output data_nibble,
                    output enable, output wait_us, output last, input ready);
    modport sink   (input valid, input reg_select, input data_nibble,
                    input enable, input wait_us, input last, output ready);
endinterface

// ----- sv/clns_front.sv -----
// ============================================================================
// clns_front
// Accepts requests, classifies them into jobs and converts numbers to
// decimal digits, one digit per cycle.
// ============================================================================
module clns_front #(
    parameter int NUMBER_DIGITS = clns_pkg::NUMBER_DIGITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    clns_req_if.sink            req,
    input  logic                q_full,
    output logic                push,
    output clns_pkg::job_t      push_job
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;
    localparam int   PAD_POS = (NUMBER_DIGITS < clns_pkg::MAX_POS) ?
                               NUMBER_DIGITS : clns_pkg::MAX_POS;

    logic                      state_reg, state_next;
    logic [15:0]               v_reg;
    logic [2:0]                nd_reg;
    clns_pkg::digit_t [clns_pkg::MAX_DIGITS-1:0] dig_reg;

    logic                      accept;
    logic [31:0]               prod;
    logic [15:0]               quot;
    logic [15:0]               rem;
    logic                      conv_done;
    logic [2:0]                nd_out;
    logic [6:0]                addr;
    clns_pkg::digit_t [clns_pkg::MAX_DIGITS-1:0] dig_cur;

    assign req.ready = (state_reg == ST_IDLE) && !q_full;
    assign accept    = req.valid && req.ready;

    // Divide by ten through the reciprocal, remainder by back-multiply
    assign prod      = 32'(v_reg) * 32'(clns_pkg::DIV10_MUL);
    assign quot      = 16'(prod >> clns_pkg::DIV10_SHIFT);
    assign rem       = v_reg - ((quot << 3) + (quot << 1));
    assign conv_done = (state_reg == ST_CONV) &&
                       ((quot == 16'd0) || (nd_reg == 3'(clns_pkg::MAX_DIGITS - 1)));
    assign nd_out    = nd_reg + 3'd1;
    assign addr      = req.row ? (clns_pkg::ROW1_BASE + {1'b0, req.column})
                               : {1'b0, req.column};

    // Job build and push
    always_comb
    begin
        dig_cur         = dig_reg;
        dig_cur[nd_reg] = rem[3:0];
        push_job        = '0;
        push            = 1'b0;
        if (state_reg == ST_CONV)
        begin
            push              = conv_done;
            push_job.kind     = clns_pkg::KIND_NUMBER;
            push_job.rs       = 1'b1;
            push_job.digits   = dig_cur;
            push_job.nd       = nd_out;
            push_job.npos     = (nd_out > 3'(PAD_POS)) ? nd_out : 3'(PAD_POS);
        end
        else
        begin
            case (req.opcode)
                clns_pkg::OP_INIT:
                begin
                    push          = accept;
                    push_job.kind = clns_pkg::KIND_INIT;
                end
                clns_pkg::OP_CMD:
                begin
                    push              = accept;
                    push_job.kind     = clns_pkg::KIND_BYTE;
                    push_job.rs       = 1'b0;
                    push_job.byte_val = req.byte_value;
                end
                clns_pkg::OP_DATA:
                begin
                    push              = accept;
                    push_job.kind     = clns_pkg::KIND_BYTE;
                    push_job.rs       = 1'b1;
                    push_job.byte_val = req.byte_value;
                end
                clns_pkg::OP_GOTO:
                begin
                    push              = accept;
                    push_job.kind     = clns_pkg::KIND_BYTE;
                    push_job.rs       = 1'b0;
                    push_job.byte_val = clns_pkg::CMD_SET_DDRAM | {1'b0, addr};
                end
                default:
                begin
                    push = 1'b0;   // numbers wait for conversion, unknown ops drop
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.opcode == clns_pkg::OP_NUMBER)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Digit engine datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            v_reg  <= req.number;
            nd_reg <= 3'd0;
        end
        else
        begin
            v_reg           <= quot;
            nd_reg          <= nd_out;
            dig_reg[nd_reg] <= rem[3:0];
        end
    end

endmodule

// ----- sv/clns_queue.sv -----
// ============================================================================
// clns_queue
// Short job queue between front and back.
// ============================================================================
module clns_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  clns_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output clns_pkg::job_t head_job
);

    localparam int PTR_W = (clns_pkg::QUEUE_DEPTH > 1) ? $clog2(clns_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(clns_pkg::QUEUE_DEPTH + 1);

    clns_pkg::job_t   mem_reg [clns_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(clns_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(clns_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(clns_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/clns_back.sv -----
// ============================================================================
// clns_back
// Walks the head job phase by phase into a registered output stage.
// ============================================================================
module clns_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  clns_pkg::job_t head_job,
    output logic           pop,
    clns_phase_if.source   phase
);

    logic [4:0]        idx_reg;
    logic              out_valid_reg;
    clns_pkg::phase_t  out_reg;
    logic              out_last_reg;

    logic              advance;
    logic [2:0]        pos;
    logic [1:0]        phn;
    logic [2:0]        dig_idx;
    logic [7:0]        num_byte;
    clns_pkg::phase_t  cur;
    logic              cur_last;

    assign advance = head_valid && (!out_valid_reg || phase.ready);
    assign pos     = idx_reg[4:2];
    assign phn     = idx_reg[1:0];
    assign dig_idx = head_job.nd - 3'd1 - pos;
    assign pop     = advance && cur_last;

    // Current phase of the head job
    always_comb
    begin
        num_byte = clns_pkg::CHAR_SPACE;
        if (pos < head_job.nd)
        begin
            num_byte = clns_pkg::CHAR_ZERO + {4'h0, head_job.digits[dig_idx]};
        end
        case (head_job.kind)
            clns_pkg::KIND_INIT:
            begin
                cur      = clns_pkg::init_phase(idx_reg);
                cur_last = (idx_reg == clns_pkg::INIT_LAST_IDX);
            end
            clns_pkg::KIND_BYTE:
            begin
                cur      = clns_pkg::byte_phase(head_job.rs, head_job.byte_val, phn);
                cur_last = (phn == 2'd3);
            end
            clns_pkg::KIND_NUMBER:
            begin
                cur      = clns_pkg::byte_phase(1'b1, num_byte, phn);
                cur_last = (phn == 2'd3) && (pos == head_job.npos - 3'd1);
            end
            default:
            begin
                cur      = '0;
                cur_last = 1'b1;
            end
        endcase
    end

    // Phase counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                idx_reg       <= cur_last ? 5'd0 : idx_reg + 5'd1;
                out_valid_reg <= 1'b1;
            end
            else if (phase.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg      <= cur;
            out_last_reg <= cur_last;
        end
    end

    assign phase.valid       = out_valid_reg;
    assign phase.reg_select  = out_reg.rs;
    assign phase.data_nibble = out_reg.nib;
    assign phase.enable      = out_reg.en;
    assign phase.wait_us     = out_reg.wait_us;
    assign phase.last        = out_last_reg;

endmodule

// ----- sv/char_lcd_nibble_sequencer_core.sv -----
// ============================================================================
// char_lcd_nibble_sequencer_core
// Character LCD 4-bit bus sequencer: turns requests into runs of pin phases.
// ============================================================================
//  channel | dir | beat                          | last beat of run
//  --------+-----+-------------------------------+------------------
//  req     | in  | one request (opcode + fields) | n/a
//  phase   | out | one pin phase (RS, D, EN, us) | phase.last = 1
//
//  Phases: one phase per cycle from the back end unless phase.ready stalls it;
//  init is 25 phases, a command, character or goto 4, a number 4 per printed
//  position. Number conversion runs in the front at one digit per cycle (up to
//  5 digits) via the divide-by-ten unit, while the back end works the queued job.
//  Reset: asynchronous, clears queue pointers, state and output valid.
//  Stalls: phase.ready low holds the output register; the two-entry job queue
//  keeps the front accepting until it fills.
// ============================================================================
module char_lcd_nibble_sequencer_core #(
    parameter int NUMBER_DIGITS = clns_pkg::NUMBER_DIGITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    clns_req_if.sink      req,
    clns_phase_if.source  phase
);

    logic           push;
    clns_pkg::job_t push_job;
    logic           q_full;
    logic           pop;
    logic           head_valid;
    clns_pkg::job_t head_job;

    clns_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    clns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .phase      (phase)
    );

endmodule

// ----- tb/sv/tb_char_lcd_nibble_sequencer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_char_lcd_nibble_sequencer_core
// Self-checking bench for the 4-bit character LCD sequencer. Requests go in
// on the request channel; every pin phase coming out is compared field by
// field against an in-bench prediction of the phase run for that request.
// Directed requests cover init, command, character, goto, number and unused
// opcodes, then random traffic runs with and without random gaps/stalls.
// ============================================================================
module tb_char_lcd_nibble_sequencer_core;

    localparam int          PAD_DIGITS      = clns_pkg::NUMBER_DIGITS_DEFAULT;
    localparam int          RUN_PHASE_CAP   = 25;
    localparam int          POSITION_CAP    = RUN_PHASE_CAP / 4;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES    = 40;
    localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

    // One expected pin phase
    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] wait_us;
        logic        last;
    } pin_phase_t;

    logic clk;
    logic rst_n;

    clns_req_if   req_ch ();
    clns_phase_if phase_ch ();

    char_lcd_nibble_sequencer_core #(
        .NUMBER_DIGITS (PAD_DIGITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .phase (phase_ch)
    );

    pin_phase_t expected_phases[$];
    pin_phase_t run_phases[$];
    int         error_count;
    int         requests_accepted;
    int         phases_checked;
    int         idle_cycles;
    bit         gaps_on;
    int         stall_left;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Phase run prediction
    // ------------------------------------------------------------------------
    function automatic void add_phase(input logic rs, input logic [3:0] nib,
                                      input logic en, input logic [15:0] hold_us);
        pin_phase_t p;
        if (run_phases.size() >= RUN_PHASE_CAP)
        begin
            return;
        end
        p.rs      = rs;
        p.nib     = nib;
        p.en      = en;
        p.wait_us = hold_us;
        p.last    = 1'b0;
        run_phases.push_back(p);
    endfunction

    // EN high for 1 us, then EN low for 100 us plus the extra hold
    function automatic void add_nibble(input logic rs, input logic [3:0] nib,
                                       input logic [15:0] extra);
        add_phase(rs, nib, 1'b1, clns_pkg::EN_HIGH_US);
        add_phase(rs, nib, 1'b0, clns_pkg::EN_LOW_US + extra);
    endfunction

    // High nibble first; clear and home commands hold 2 ms longer
    function automatic void add_byte(input logic rs, input logic [7:0] b);
        logic [15:0] extra;
        extra = clns_pkg::BYTE_TAIL_US;
        if (!rs && (b == clns_pkg::CMD_CLEAR || b == clns_pkg::CMD_HOME))
        begin
            extra = clns_pkg::BYTE_TAIL_US + clns_pkg::CLEAR_TAIL_US;
        end
        add_nibble(rs, b[7:4], 16'd0);
        add_nibble(rs, b[3:0], extra);
    endfunction

    function automatic void predict_phase_run(input logic [2:0] op,
                                              input logic [7:0] bv,
                                              input logic row,
                                              input logic [5:0] col,
                                              input logic [15:0] num);
        logic [6:0] addr;
        logic [3:0] digits [clns_pkg::MAX_DIGITS];
        int         nd;
        int         npos;
        int         v;
        run_phases.delete();
        case (op)
            clns_pkg::OP_INIT:
            begin
                add_phase(1'b0, 4'h0, 1'b0, clns_pkg::POWER_UP_US);
                add_nibble(1'b0, clns_pkg::NIB_WAKE, clns_pkg::WAKE0_US);
                add_nibble(1'b0, clns_pkg::NIB_WAKE, clns_pkg::WAKE1_US);
                add_nibble(1'b0, clns_pkg::NIB_WAKE, 16'd0);
                add_nibble(1'b0, clns_pkg::NIB_4BIT, 16'd0);
                add_byte(1'b0, clns_pkg::CMD_FUNC_4BIT);
                add_byte(1'b0, clns_pkg::CMD_DISP_ON);
                add_byte(1'b0, clns_pkg::CMD_ENTRY);
                add_byte(1'b0, clns_pkg::CMD_CLEAR);
            end
            clns_pkg::OP_CMD:
            begin
                add_byte(1'b0, bv);
            end
            clns_pkg::OP_DATA:
            begin
                add_byte(1'b1, bv);
            end
            clns_pkg::OP_GOTO:
            begin
                addr = row ? (clns_pkg::ROW1_BASE + 7'(col)) : 7'(col);
                add_byte(1'b0, clns_pkg::CMD_SET_DDRAM | {1'b0, addr});
            end
            clns_pkg::OP_NUMBER:
            begin
                // digits least significant first, left-justified, space padded
                v  = int'(num);
                nd = 0;
                do
                begin
                    digits[nd] = 4'(v % 10);
                    v = v / 10;
                    nd++;
                end
                while (v != 0 && nd < clns_pkg::MAX_DIGITS);
                npos = 0;
                for (int i = nd - 1; i >= 0 && npos < POSITION_CAP; i--)
                begin
                    add_byte(1'b1, clns_pkg::CHAR_ZERO + 8'(digits[i]));
                    npos++;
                end
                for (int i = nd; i < PAD_DIGITS && npos < POSITION_CAP; i++)
                begin
                    add_byte(1'b1, clns_pkg::CHAR_SPACE);
                    npos++;
                end
            end
            default:
            begin
                // unused opcodes give no phases
            end
        endcase
        if (run_phases.size() > 0)
        begin
            run_phases[run_phases.size() - 1].last = 1'b1;
        end
        foreach (run_phases[i])
        begin
            expected_phases.push_back(run_phases[i]);
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Phase sink: random backpressure when gaps are on
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!gaps_on)
        begin
            stall_left     <= 0;
            phase_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left     <= stall_left - 1;
            phase_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left     <= pick_gap() - 1;
            phase_ch.ready <= 1'b0;
        end
        else
        begin
            phase_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Phase checker: each beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pin_phase_t want;
        if (rst_n && phase_ch.valid && phase_ch.ready)
        begin
            if (expected_phases.size() == 0)
            begin
                $error("phase beat with nothing expected: rs=%0b nib=%h en=%0b wait=%0d last=%0b",
                       phase_ch.reg_select, phase_ch.data_nibble, phase_ch.enable,
                       phase_ch.wait_us, phase_ch.last);
                error_count++;
            end
            else
            begin
                want = expected_phases.pop_front();
                phases_checked++;
                if (phase_ch.reg_select !== want.rs)
                begin
                    $error("reg_select: expected %0b, got %0b", want.rs,
                           phase_ch.reg_select);
                    error_count++;
                end
                if (phase_ch.data_nibble !== want.nib)
                begin
                    $error("data_nibble: expected %h, got %h", want.nib,
                           phase_ch.data_nibble);
                    error_count++;
                end
                if (phase_ch.enable !== want.en)
                begin
                    $error("enable: expected %0b, got %0b", want.en, phase_ch.enable);
                    error_count++;
                end
                if (phase_ch.wait_us !== want.wait_us)
                begin
                    $error("wait_us: expected %0d, got %0d", want.wait_us,
                           phase_ch.wait_us);
                    error_count++;
                end
                if (phase_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, phase_ch.last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles in a row with no beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (phase_ch.valid && phase_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d phases outstanding",
                     WATCHDOG_LIMIT, expected_phases.size());
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: one beat, prediction made at acceptance
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] op, input logic [7:0] bv,
                                input logic row, input logic [5:0] col,
                                input logic [15:0] num);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.byte_value <= bv;
        req_ch.row        <= row;
        req_ch.column     <= col;
        req_ch.number     <= num;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predict_phase_run(op, bv, row, col, num);
        requests_accepted++;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_phases();
        while (expected_phases.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_init_sequence();
        send_request(clns_pkg::OP_INIT, 8'h00, 1'b0, 6'd0, 16'd0);
    endtask

    task automatic test_command_bytes();
        send_request(clns_pkg::OP_CMD, 8'h00, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_CMD, 8'hFF, 1'b1, 6'd63, 16'hFFFF);
        send_request(clns_pkg::OP_CMD, clns_pkg::CMD_CLEAR, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_CMD, clns_pkg::CMD_HOME, 1'b0, 6'd0, 16'd0);
    endtask

    // a data 0x01 must not get the clear hold
    task automatic test_data_characters();
        send_request(clns_pkg::OP_DATA, 8'h00, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_DATA, 8'hFF, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_DATA, clns_pkg::CMD_CLEAR, 1'b0, 6'd0, 16'd0);
    endtask

    task automatic test_cursor_goto();
        send_request(clns_pkg::OP_GOTO, 8'hFF, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_GOTO, 8'h00, 1'b1, 6'd39, 16'd0);
        send_request(clns_pkg::OP_GOTO, 8'h00, 1'b1, 6'd63, 16'd0);
        send_request(clns_pkg::OP_GOTO, 8'h00, 1'b0, 6'd63, 16'd0);
    endtask

    // single digit, five digits, and values past the signed range
    task automatic test_number_print();
        send_request(clns_pkg::OP_NUMBER, 8'h00, 1'b0, 6'd0, 16'd0);
        send_request(clns_pkg::OP_NUMBER, 8'h00, 1'b0, 6'd0, 16'd9);
        send_request(clns_pkg::OP_NUMBER, 8'h00, 1'b0, 6'd0, 16'd10000);
        send_request(clns_pkg::OP_NUMBER, 8'h00, 1'b0, 6'd0, 16'd32768);
        send_request(clns_pkg::OP_NUMBER, 8'h00, 1'b0, 6'd0, 16'd65535);
    endtask

    task automatic test_ignored_opcodes();
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
        begin
            send_request(3'(op), 8'hFF, 1'b1, 6'd63, 16'hFFFF);
        end
        send_request(clns_pkg::OP_DATA, 8'h41, 1'b0, 6'd0, 16'd0);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: count excludes unused opcodes
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int count);
        int          sent;
        int          pick;
        logic [2:0]  op;
        logic [15:0] num;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                op = clns_pkg::OP_INIT;
            end
            else if (pick < 25)
            begin
                op = clns_pkg::OP_CMD;
            end
            else if (pick < 50)
            begin
                op = clns_pkg::OP_DATA;
            end
            else if (pick < 70)
            begin
                op = clns_pkg::OP_GOTO;
            end
            else if (pick < 95)
            begin
                op = clns_pkg::OP_NUMBER;
            end
            else
            begin
                op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            end
            // spread numbers over all digit counts
            case ($urandom_range(0, 5))
                0:       num = 16'($urandom_range(0, 9));
                1:       num = 16'($urandom_range(10, 99));
                2:       num = 16'($urandom_range(100, 999));
                3:       num = 16'($urandom_range(1000, 9999));
                4:       num = 16'($urandom_range(10000, 65535));
                default: num = 16'($urandom_range(0, 65535));
            endcase
            send_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         6'($urandom_range(0, 63)), num);
            if (op <= clns_pkg::OP_NUMBER)
            begin
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        gaps_on             = 1'b0;
        stall_left          = 0;
        idle_cycles         = 0;
        error_count         = 0;
        requests_accepted   = 0;
        phases_checked      = 0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = clns_pkg::OP_INIT;
        req_ch.byte_value   = 8'h00;
        req_ch.row          = 1'b0;
        req_ch.column       = 6'd0;
        req_ch.number       = 16'd0;
        phase_ch.ready      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first directed tests back to back, the rest with gaps and stalls
        test_init_sequence();
        test_command_bytes();
        test_data_characters();
        gaps_on = 1'b1;
        test_cursor_goto();
        test_number_print();
        test_ignored_opcodes();
        test_init_sequence();

        test_random_traffic(280);
        gaps_on = 1'b0;
        test_random_traffic(150);

        req_ch.valid <= 1'b0;
        drain_phases();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (init, command, character, goto, number, unused)",
                 requests_accepted);
        $display("checked %0d pin phases under random gaps, stalls and back-to-back traffic",
                 phases_checked);
        if (error_count == 0 && expected_phases.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches, %0d phases never seen", error_count,
                     expected_phases.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
